// File: hw/rtl/bf_pkg.sv
package bf_pkg;

   localparam int PIX_W      = 8;
   localparam int POS_W      = 10;
   localparam int CSR_DATA_W = 11;
   localparam int CSR_IDX_W  = 1;
   localparam int COL_SUM_W  = 10;
   localparam int SUM_W      = 12;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;
   localparam int DIM_RESET      = 1024;

   // floor(x / 9) == (x * 7282) >> 16 for every x below 32768
   localparam int MULT_W            = 13;
   localparam logic [MULT_W-1:0] MEAN_MULT = 13'd7282;
   localparam int MEAN_SHIFT        = 16;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = 2;
   localparam int FIFO_CW    = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 1'd1;

   typedef struct packed {
      logic [PIX_W-1:0] top;
      logic [PIX_W-1:0] mid;
      logic [PIX_W-1:0] bot;
   } col_type;

   typedef struct packed {
      logic [PIX_W-1:0] mean_value;
      logic [POS_W-1:0] center_row;
      logic [POS_W-1:0] center_col;
      logic             frame_last;
   } result_type;

   function automatic logic [COL_SUM_W-1:0] col_sum(input col_type col);
      col_sum = COL_SUM_W'(col.top) + COL_SUM_W'(col.mid) + COL_SUM_W'(col.bot);
   endfunction

endpackage

// File: hw/rtl/bf_ram.sv
module bf_ram import bf_pkg::*; #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

// File: hw/rtl/bf_col_cell.sv
module bf_col_cell import bf_pkg::*; (
   input  logic                 clock,
   input  logic                 shift,
   input  col_type              col_in,
   output col_type              col_ff,
   output logic [COL_SUM_W-1:0] sum
);

   always_ff @(posedge clock) begin
      if (shift) begin
         col_ff <= col_in;
      end
   end

   assign sum = col_sum(col_ff);

endmodule

// File: hw/rtl/bf_out_fifo.sv
module bf_out_fifo import bf_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  result_type         push_data,
   input  logic               pop,
   output logic               out_valid,
   output result_type         head,
   output logic [FIFO_CW-1:0] count
);

   result_type         slot_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CW-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign out_valid = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

// File: hw/rtl/box_filter_3x3_mean.sv
// 3x3 box mean filter over a raster pixel stream.
// a result is offered once the request of its lower right pixel is accepted and has
// passed the stage 1 and stage 2 registers and been pushed into the result queue.
// throughput: 1 pixel per cycle while requests are not stalled; one line store read and one write per cycle set it.
// requests stall only while four results are queued or still in the pipeline.
// reset clears counters, the result queue and pipeline valids and sets both
// dimensions to 1024 (clamped to the maximums); line stores are not cleared.
module box_filter_3x3_mean import bf_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [PIX_W-1:0]      req_pixel,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [PIX_W-1:0]      rsp_mean_value,
   output logic [POS_W-1:0]      rsp_center_row,
   output logic [POS_W-1:0]      rsp_center_col,
   output logic                  rsp_frame_last,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int RST_LAST_COL = ((MAX_WIDTH < DIM_RESET) ? MAX_WIDTH : DIM_RESET) - 1;
   localparam int RST_LAST_ROW = ((MAX_HEIGHT < DIM_RESET) ? MAX_HEIGHT : DIM_RESET) - 1;
   localparam int PROD_W = SUM_W + MULT_W;

   // configuration, held as last column / last row index
   logic [CW-1:0] last_col_ff, last_col_in;
   logic [RW-1:0] last_row_ff, last_row_in;
   logic [31:0]   csr_val;

   always_comb begin
      csr_val = 32'(csr_wdata);
      if (csr_val < 32'd3) begin
         last_col_in = CW'(2);
         last_row_in = RW'(2);
      end else begin
         last_col_in = (csr_val > 32'(MAX_WIDTH)) ? CW'(MAX_WIDTH - 1) : CW'(csr_val - 32'd1);
         last_row_in = (csr_val > 32'(MAX_HEIGHT)) ? RW'(MAX_HEIGHT - 1)
                                                   : RW'(csr_val - 32'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_col_ff <= CW'(RST_LAST_COL);
         last_row_ff <= RW'(RST_LAST_ROW);
      end else if (csr_write) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  last_col_ff <= last_col_in;
            CSR_IMAGE_HEIGHT: last_row_ff <= last_row_in;
            default: begin
            end
         endcase
      end
   end

   // position counters
   logic          accept;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic          row_end, frame_end, emit;
   logic [31:0]   row_m1, col_m1;

   assign accept    = req_valid && !req_stall;
   assign row_end   = (col_ff >= last_col_ff);
   assign frame_end = (row_ff >= last_row_ff);
   assign emit      = (32'(row_ff) >= 32'd2) && (32'(col_ff) >= 32'd2);
   assign row_m1    = 32'(row_ff) - 32'd1;
   assign col_m1    = 32'(col_ff) - 32'd1;

   always_comb begin
      col_in = col_ff + 1'b1;
      row_in = row_ff;
      if (row_end) begin
         col_in = '0;
         row_in = frame_end ? '0 : row_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // stage 1: line store data returns, stores get rewritten, window shifts
   logic             s1_valid_ff;
   logic             s1_emit_ff;
   logic [CW-1:0]    s1_col_ff;
   logic [PIX_W-1:0] s1_pixel_ff;
   result_type       s1_info_ff;
   logic [2*PIX_W-1:0] store_rd;
   col_type          cur_col;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_emit_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s1_emit_ff  <= accept && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_ff              <= col_ff;
         s1_pixel_ff            <= req_pixel;
         s1_info_ff.mean_value  <= '0;
         s1_info_ff.center_row  <= row_m1[POS_W-1:0];
         s1_info_ff.center_col  <= col_m1[POS_W-1:0];
         s1_info_ff.frame_last  <= row_end && frame_end;
      end
   end

   // upper row in the high byte, middle row in the low byte
   bf_ram #(.WIDTH(2*PIX_W), .DEPTH(MAX_WIDTH)) u_line_store (
      .clock      (clock),
      .wr_en      (s1_valid_ff),
      .wr_addr    (s1_col_ff),
      .wr_data    ({store_rd[PIX_W-1:0], s1_pixel_ff}),
      .rd_en      (accept),
      .rd_addr    (col_ff),
      .rd_data_ff (store_rd)
   );

   assign cur_col.top = store_rd[2*PIX_W-1:PIX_W];
   assign cur_col.mid = store_rd[PIX_W-1:0];
   assign cur_col.bot = s1_pixel_ff;

   // two cells keep the previous two columns of the window
   col_type              link [3];
   logic [COL_SUM_W-1:0] cell_sum [2];

   assign link[0] = cur_col;

   for (genvar k = 0; k < 2; k++) begin : g_cell
      bf_col_cell u_cell (
         .clock  (clock),
         .shift  (s1_valid_ff),
         .col_in (link[k]),
         .col_ff (link[k+1]),
         .sum    (cell_sum[k])
      );
   end

   // stage 2: window total
   logic             s2_emit_ff;
   logic [SUM_W-1:0] s2_total_ff;
   result_type       s2_info_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_emit_ff <= 1'b0;
      end else begin
         s2_emit_ff <= s1_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_emit_ff) begin
         s2_total_ff <= SUM_W'(col_sum(cur_col)) + SUM_W'(cell_sum[0])
                        + SUM_W'(cell_sum[1]);
         s2_info_ff  <= s1_info_ff;
      end
   end

   // divide by nine through the reciprocal, then queue the result
   logic [PROD_W-1:0]  prod;
   result_type         push_data, head;
   logic               fifo_valid, pop;
   logic [FIFO_CW-1:0] fifo_count;
   logic [FIFO_CW:0]   pending;

   always_comb begin
      prod                 = PROD_W'(s2_total_ff) * PROD_W'(MEAN_MULT);
      push_data            = s2_info_ff;
      push_data.mean_value = prod[MEAN_SHIFT +: PIX_W];
   end

   bf_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s2_emit_ff),
      .push_data (push_data),
      .pop       (pop),
      .out_valid (fifo_valid),
      .head      (head),
      .count     (fifo_count)
   );

   // results in flight always have a queue slot reserved
   assign pending   = (FIFO_CW+1)'(fifo_count) + (FIFO_CW+1)'(s1_emit_ff)
                      + (FIFO_CW+1)'(s2_emit_ff);
   assign req_stall = (pending >= (FIFO_CW+1)'(FIFO_DEPTH));
   assign pop       = fifo_valid && !rsp_stall;

   assign rsp_valid      = fifo_valid;
   assign rsp_mean_value = head.mean_value;
   assign rsp_center_row = head.center_row;
   assign rsp_center_col = head.center_col;
   assign rsp_frame_last = head.frame_last;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      pending <= (FIFO_CW+1)'(FIFO_DEPTH))
      else $error("result queue overcommitted");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      s2_emit_ff |-> (fifo_count < FIFO_CW'(FIFO_DEPTH)) || pop)
      else $error("push into full result queue");

   a_accept_flows: assert property (@(posedge clock) disable iff (reset)
      (accept && emit) |=> s1_emit_ff ##1 s2_emit_ff)
      else $error("request lost in pipeline");

   a_emit_needs_valid: assert property (@(posedge clock) disable iff (reset)
      s1_emit_ff |-> s1_valid_ff)
      else $error("emit without valid stage");

endmodule

// File: sim/box_filter_3x3_mean_test.sv
`timescale 1ns / 1ps

module box_filter_3x3_mean_test;
   import bf_pkg::*;

   typedef enum {PACE_SLOW_SINK, PACE_SLOW_SOURCE, PACE_FULL} pace_type;
   typedef enum {PIX_UNIFORM, PIX_EXTREME, PIX_BRIGHT, PIX_DARK} pixel_style_type;

   localparam int RANDOM_PIXELS = 450;
   localparam int HOLD_CYCLES   = 300;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [PIX_W-1:0]      req_pixel = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [PIX_W-1:0]      rsp_mean_value;
   logic [POS_W-1:0]      rsp_center_row;
   logic [POS_W-1:0]      rsp_center_col;
   logic                  rsp_frame_last;
   logic                  csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   box_filter_3x3_mean u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pixel      (req_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_mean_value (rsp_mean_value),
      .rsp_center_row (rsp_center_row),
      .rsp_center_col (rsp_center_col),
      .rsp_frame_last (rsp_frame_last),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #4 clock = ~clock;

   // filter state mirrored on the testbench side
   logic [CSR_DATA_W-1:0] cfg_width  = CSR_DATA_W'(DIM_RESET);
   logic [CSR_DATA_W-1:0] cfg_height = CSR_DATA_W'(DIM_RESET);
   logic [PIX_W-1:0]      upper_line  [DEF_MAX_WIDTH];
   logic [PIX_W-1:0]      middle_line [DEF_MAX_WIDTH];
   logic [PIX_W-1:0]      window [6];
   int unsigned           col_pos = 0;
   int unsigned           row_pos = 0;

   logic [PIX_W-1:0] pixel_feed [$];
   result_type       pending_means [$];
   bit               pixel_taken = 1'b0;
   int               error_count = 0;
   pace_type         pace = PACE_SLOW_SINK;
   bit               hold_wanted = 1'b0;
   bit               hold_done   = 1'b0;
   int               hold_left   = 0;

   initial begin
      foreach (upper_line[i]) begin
         upper_line[i]  = '0;
         middle_line[i] = '0;
      end
      foreach (window[i]) window[i] = '0;
   end

   function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
      if (v < 3) return 3;
      if (v > hi) return hi;
      return v;
   endfunction

   // advance the mirrored filter by one pixel; returns 1 when a mean is produced
   function automatic bit box_mean_step(input logic [PIX_W-1:0] pix, output result_type res);
      int unsigned w, h, c, r, sum;
      logic [PIX_W-1:0] top, mid;
      bit row_end, frame_end, hit;
      w = clamp_dim(cfg_width, DEF_MAX_WIDTH);
      h = clamp_dim(cfg_height, DEF_MAX_HEIGHT);
      c = col_pos;
      r = row_pos;
      top = '0;
      mid = '0;
      row_end = (c >= w - 1);
      frame_end = (r >= h - 1);
      if (c < DEF_MAX_WIDTH) begin
         top = upper_line[c];
         mid = middle_line[c];
         upper_line[c] = mid;
         middle_line[c] = pix;
      end
      hit = (r >= 2 && c >= 2);
      res = '0;
      if (hit) begin
         sum = top + mid + pix;
         foreach (window[i]) sum += window[i];
         res.mean_value = PIX_W'(sum / 9);
         res.center_row = POS_W'(r - 1);
         res.center_col = POS_W'(c - 1);
         res.frame_last = row_end && frame_end;
      end
      window[0] = window[3];
      window[1] = window[4];
      window[2] = window[5];
      window[3] = top;
      window[4] = mid;
      window[5] = pix;
      if (row_end) begin
         col_pos = 0;
         row_pos = frame_end ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
      end
      return hit;
   endfunction

   // pixels still needed to close the current frame at the given dimensions
   function automatic int unsigned pixels_to_frame_end(input int unsigned w, input int unsigned h);
      int unsigned cols, rows;
      if (col_pos == 0 && row_pos == 0) return 0;
      cols = (col_pos >= w - 1) ? 1 : w - col_pos;
      rows = (row_pos >= h - 1) ? 0 : h - 1 - row_pos;
      return cols + rows * w;
   endfunction

   function automatic logic [PIX_W-1:0] pick_pixel(input pixel_style_type style);
      case (style)
         PIX_EXTREME: return $urandom_range(1, 0) ? 8'hFF : 8'h00;
         PIX_BRIGHT:  return PIX_W'($urandom_range(255, 240));
         PIX_DARK:    return PIX_W'($urandom_range(15, 0));
         default:     return PIX_W'($urandom_range(255, 0));
      endcase
   endfunction

   task automatic push_pixels(input int unsigned count, input pixel_style_type style);
      repeat (count) pixel_feed.push_back(pick_pixel(style));
   endtask

   task automatic write_dims(input int unsigned w_val, input int unsigned h_val);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= CSR_IMAGE_WIDTH;
      csr_wdata <= CSR_DATA_W'(w_val);
      @(negedge clock);
      csr_index <= CSR_IMAGE_HEIGHT;
      csr_wdata <= CSR_DATA_W'(h_val);
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   // all requests taken, all means seen, then room for pixels still in the pipe
   task automatic wait_drained();
      do @(posedge clock); while (pixel_feed.size() != 0 || req_valid);
      while (pending_means.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // request side
   always @(negedge clock) begin
      int idle_pct;
      case (pace)
         PACE_SLOW_SINK:   idle_pct = 7;
         PACE_SLOW_SOURCE: idle_pct = 75;
         default:          idle_pct = 0;
      endcase
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || pixel_taken) begin
         if (pixel_feed.size() != 0 && $urandom_range(99, 0) >= idle_pct) begin
            req_valid <= 1'b1;
            req_pixel <= pixel_feed.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result side stall, with one long hold-off on request
   always @(negedge clock) begin
      int idle_pct;
      case (pace)
         PACE_SLOW_SINK:   idle_pct = 75;
         PACE_SLOW_SOURCE: idle_pct = 7;
         default:          idle_pct = 0;
      endcase
      if (hold_wanted && !hold_done) begin
         hold_left = HOLD_CYCLES;
         hold_done = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99, 0) < idle_pct);
      end
   end

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         pixel_taken = 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:  cfg_width = csr_wdata;
               CSR_IMAGE_HEIGHT: cfg_height = csr_wdata;
               default: ;
            endcase
         end
         pixel_taken = req_valid && !req_stall;
         if (pixel_taken && box_mean_step(req_pixel, want)) pending_means.push_back(want);
         if (rsp_valid && !rsp_stall) begin
            if (pending_means.size() == 0) begin
               $error("unexpected result: row %0d col %0d mean %0d",
                      rsp_center_row, rsp_center_col, rsp_mean_value);
               error_count++;
            end else begin
               want = pending_means.pop_front();
               if (rsp_mean_value !== want.mean_value) begin
                  $error("mean_value: expected %0d, actual %0d", want.mean_value, rsp_mean_value);
                  error_count++;
               end
               if (rsp_center_row !== want.center_row) begin
                  $error("center_row: expected %0d, actual %0d", want.center_row, rsp_center_row);
                  error_count++;
               end
               if (rsp_center_col !== want.center_col) begin
                  $error("center_col: expected %0d, actual %0d", want.center_col, rsp_center_col);
                  error_count++;
               end
               if (rsp_frame_last !== want.frame_last) begin
                  $error("frame_last: expected %0d, actual %0d", want.frame_last, rsp_frame_last);
                  error_count++;
               end
            end
         end
      end
   end

   initial begin
      int unsigned     random_sent, w_val, h_val, w, h, count;
      pixel_style_type style;

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // small dims clamp up to 3x3; two frames back to back check the wrap
      pace = PACE_SLOW_SINK;
      write_dims(0, 2);
      repeat (9) pixel_feed.push_back(8'hFF);
      repeat (9) pixel_feed.push_back(8'h00);
      wait_drained();
      // one low pixel shows the division truncates
      write_dims(1, 3);
      repeat (8) pixel_feed.push_back(8'hFF);
      pixel_feed.push_back(8'hFE);
      wait_drained();

      random_sent = 0;
      while (random_sent < RANDOM_PIXELS) begin
         if (random_sent < RANDOM_PIXELS / 3) pace = PACE_SLOW_SINK;
         else if (random_sent < 2 * RANDOM_PIXELS / 3) pace = PACE_SLOW_SOURCE;
         else pace = PACE_FULL;
         if (col_pos == 0 && row_pos == 0) begin
            if ($urandom_range(7, 0) == 0) w_val = $urandom_range(2, 0);
            else if ($urandom_range(9, 0) == 0) w_val = $urandom_range(40, 13);
            else w_val = $urandom_range(12, 3);
         end else begin
            // mid-frame the width may only shrink, so no unwritten column is read
            w_val = $urandom_range(clamp_dim(cfg_width, DEF_MAX_WIDTH), 0);
         end
         h_val = ($urandom_range(7, 0) == 0) ? $urandom_range(2, 0) : $urandom_range(8, 3);
         write_dims(w_val, h_val);
         w = clamp_dim(w_val, DEF_MAX_WIDTH);
         h = clamp_dim(h_val, DEF_MAX_HEIGHT);
         count = pixels_to_frame_end(w, h);
         if (count == 0) count = w * h * $urandom_range(2, 1);
         else count += w * h * $urandom_range(1, 0);
         if ($urandom_range(3, 0) == 0) count += $urandom_range(w * h - 1, 1);
         style = $urandom_range(1, 0) ? PIX_UNIFORM : pixel_style_type'($urandom_range(3, 0));
         push_pixels(count, style);
         random_sent += count;
         wait_drained();
      end

      // close any open frame before the width grows
      push_pixels(pixels_to_frame_end(clamp_dim(cfg_width, DEF_MAX_WIDTH),
                                      clamp_dim(cfg_height, DEF_MAX_HEIGHT)), PIX_UNIFORM);
      wait_drained();

      // oversized width clamps to the widest row
      pace = PACE_FULL;
      write_dims(2047, 3);
      push_pixels(DEF_MAX_WIDTH, PIX_UNIFORM);
      wait_drained();

      // narrow the rest of the frame, with a long result hold-off so the input backs up
      write_dims(8, 3);
      hold_wanted = 1'b1;
      push_pixels(pixels_to_frame_end(8, 3) + 24, PIX_UNIFORM);
      wait_drained();

      // tallest frame cut short by a height change mid-row
      write_dims(4, 1100);
      push_pixels(4 * 40 + 2, PIX_UNIFORM);
      wait_drained();
      write_dims(4, 1);
      push_pixels(pixels_to_frame_end(4, 3), PIX_UNIFORM);
      wait_drained();

      if (error_count == 0) begin
         $display("PASS box_filter_3x3_mean");
      end else begin
         $display("FAIL box_filter_3x3_mean");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("FAIL box_filter_3x3_mean");
      $finish;
   end

endmodule

// File: box_filter_3x3_mean.f
hw/rtl/bf_pkg.sv
hw/rtl/bf_ram.sv
hw/rtl/bf_col_cell.sv
hw/rtl/bf_out_fifo.sv
hw/rtl/box_filter_3x3_mean.sv
sim/box_filter_3x3_mean_test.sv
